@@ rtl/core/dlr_pkg.sv @@
package dlr_pkg;

   localparam int FIELD_BITS = 10;
   localparam int COORD_BITS_DEFAULT = 10;
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef struct packed {
      logic                  command;
      logic [FIELD_BITS-1:0] x_start;
      logic [FIELD_BITS-1:0] y_start;
      logic [FIELD_BITS-1:0] x_end;
      logic [FIELD_BITS-1:0] y_end;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] pixel_x;
      logic [FIELD_BITS-1:0] pixel_y;
      logic                  last_pixel;
   } rsp_type;

endpackage

@@ rtl/core/dda_line_rasterizer_unit.sv @@
// a step beat's pixel is registered and shows on rsp in the cycle after it is taken
// throughput: one step beat per cycle while the result side does not stall
// a start beat holds the input while one restoring divider (one compare and
// subtract) forms the x then the y increment, a bit per cycle
// a zero-length line needs no division and the block is ready in the next cycle
// synchronous reset clears the sequencer, the result valid and the pixel count
module dda_line_rasterizer_unit #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEFAULT,
   parameter int FRAC_BITS = dlr_pkg::FRAC_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dlr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dlr_pkg::rsp_type rsp_data
);

   localparam int CW = (COORD_BITS < dlr_pkg::FIELD_BITS) ? COORD_BITS : dlr_pkg::FIELD_BITS;
   localparam int AW = CW + FRAC_BITS;
   localparam int IW = FRAC_BITS + 2;
   localparam int QW = FRAC_BITS + 1;
   localparam int CNTW = $clog2(QW);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV_X = 2'd1;
   localparam logic [1:0] ST_DIV_Y = 2'd2;

   logic [1:0]      state_ff, state_in;
   logic [AW-1:0]   acc_x_ff, acc_x_in;
   logic [AW-1:0]   acc_y_ff, acc_y_in;
   logic [IW-1:0]   inc_x_ff, inc_x_in;
   logic [IW-1:0]   inc_y_ff, inc_y_in;
   logic [CW-1:0]   remaining_ff, remaining_in;
   logic [CW-1:0]   div_steps_ff, div_steps_in;
   logic [CW:0]     rem_ff, rem_in;
   logic [QW-1:0]   quot_ff, quot_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0]   dy_mag_ff, dy_mag_in;
   logic            x_neg_ff, x_neg_in;
   logic            y_neg_ff, y_neg_in;
   logic            rsp_valid_ff, rsp_valid_in;
   dlr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [CW-1:0] xs, ys, xe, ye;
   logic [CW:0]   dx, dy, dx_neg, dy_neg;
   logic [CW-1:0] dx_mag, dy_mag, steps;
   logic          req_take;
   logic          ge;
   logic [CW:0]   rem_sub;
   logic [QW-1:0] quot_next;
   logic          last_bit;
   logic [IW-1:0] inc_mag, inc_val;
   logic          div_neg;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assign xs = req_data.x_start[CW-1:0];
   assign ys = req_data.y_start[CW-1:0];
   assign xe = req_data.x_end[CW-1:0];
   assign ye = req_data.y_end[CW-1:0];
   assign dx = {1'b0, xe} - {1'b0, xs};
   assign dy = {1'b0, ye} - {1'b0, ys};
   assign dx_neg = -dx;
   assign dy_neg = -dy;
   assign dx_mag = dx[CW] ? dx_neg[CW-1:0] : dx[CW-1:0];
   assign dy_mag = dy[CW] ? dy_neg[CW-1:0] : dy[CW-1:0];
   assign steps = (dx_mag >= dy_mag) ? dx_mag : dy_mag;

   // shared divider step
   assign ge = rem_ff >= {1'b0, div_steps_ff};
   assign rem_sub = ge ? (rem_ff - {1'b0, div_steps_ff}) : rem_ff;
   assign quot_next = {quot_ff[QW-2:0], ge};
   assign last_bit = cnt_ff == CNTW'(QW - 1);
   assign div_neg = (state_ff == ST_DIV_X) ? x_neg_ff : y_neg_ff;
   assign inc_mag = {1'b0, quot_next};
   assign inc_val = div_neg ? -inc_mag : inc_mag;

   always_comb begin
      state_in = state_ff;
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      inc_x_in = inc_x_ff;
      inc_y_in = inc_y_ff;
      remaining_in = remaining_ff;
      div_steps_in = div_steps_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      cnt_in = cnt_ff;
      dy_mag_in = dy_mag_ff;
      x_neg_in = x_neg_ff;
      y_neg_in = y_neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.command == dlr_pkg::CMD_START) begin
                  acc_x_in = {xs, {FRAC_BITS{1'b0}}};
                  acc_y_in = {ys, {FRAC_BITS{1'b0}}};
                  remaining_in = steps;
                  div_steps_in = steps;
                  rem_in = {1'b0, dx_mag};
                  quot_in = '0;
                  cnt_in = '0;
                  dy_mag_in = dy_mag;
                  x_neg_in = dx[CW];
                  y_neg_in = dy[CW];
                  if (steps == '0) begin
                     inc_x_in = '0;
                     inc_y_in = '0;
                  end else begin
                     state_in = ST_DIV_X;
                  end
               end else if (remaining_ff != '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in.pixel_x = dlr_pkg::FIELD_BITS'(acc_x_ff[AW-1:FRAC_BITS]);
                  rsp_data_in.pixel_y = dlr_pkg::FIELD_BITS'(acc_y_ff[AW-1:FRAC_BITS]);
                  rsp_data_in.last_pixel = remaining_ff == CW'(1);
                  acc_x_in = acc_x_ff + {{(AW-IW){inc_x_ff[IW-1]}}, inc_x_ff};
                  acc_y_in = acc_y_ff + {{(AW-IW){inc_y_ff[IW-1]}}, inc_y_ff};
                  remaining_in = remaining_ff - CW'(1);
               end
            end
         end
         ST_DIV_X, ST_DIV_Y: begin
            rem_in = {rem_sub[CW-1:0], 1'b0};
            quot_in = quot_next;
            cnt_in = cnt_ff + CNTW'(1);
            if (last_bit) begin
               cnt_in = '0;
               quot_in = '0;
               if (state_ff == ST_DIV_X) begin
                  inc_x_in = inc_val;
                  rem_in = {1'b0, dy_mag_ff};
                  state_in = ST_DIV_Y;
               end else begin
                  inc_y_in = inc_val;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_x_ff <= acc_x_in;
      acc_y_ff <= acc_y_in;
      inc_x_ff <= inc_x_in;
      inc_y_ff <= inc_y_in;
      div_steps_ff <= div_steps_in;
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      cnt_ff <= cnt_in;
      dy_mag_ff <= dy_mag_in;
      x_neg_ff <= x_neg_in;
      y_neg_ff <= y_neg_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ tb/dlr_pixel_checker.sv @@
module dlr_pixel_checker
   import dlr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pixels_pending,
   output int      lines_started,
   output int      empty_lines,
   output int      pixels_checked,
   output int      idle_steps
);

   localparam int FRAC = FRAC_BITS_DEFAULT;

   // line state: positions in coord.frac, increments signed
   longint      x_pos;
   longint      y_pos;
   longint      x_inc;
   longint      y_inc;
   int unsigned pixels_left;
   rsp_type     pixel_queue[$];

   initial begin
      fail_count = 0;
      pixels_pending = 0;
      lines_started = 0;
      empty_lines = 0;
      pixels_checked = 0;
      idle_steps = 0;
   end

   function automatic void trace_beat(input req_type beat);
      longint  x0, y0, dx, dy, adx, ady, span;
      rsp_type pixel;
      if (beat.command == CMD_START) begin
         x0 = longint'(beat.x_start);
         y0 = longint'(beat.y_start);
         dx = longint'(beat.x_end) - x0;
         dy = longint'(beat.y_end) - y0;
         adx = (dx < 0) ? -dx : dx;
         ady = (dy < 0) ? -dy : dy;
         span = (adx >= ady) ? adx : ady;
         x_pos = x0 <<< FRAC;
         y_pos = y0 <<< FRAC;
         if (span == 0) begin
            x_inc = 0;
            y_inc = 0;
            empty_lines++;
         end else begin
            // signed division truncates toward zero
            x_inc = (dx <<< FRAC) / span;
            y_inc = (dy <<< FRAC) / span;
         end
         pixels_left = int'(span);
         lines_started++;
      end else if (pixels_left == 0) begin
         idle_steps++;
      end else begin
         pixel.pixel_x = FIELD_BITS'(x_pos >>> FRAC);
         pixel.pixel_y = FIELD_BITS'(y_pos >>> FRAC);
         pixel.last_pixel = (pixels_left == 1);
         pixel_queue.push_back(pixel);
         x_pos += x_inc;
         y_pos += y_inc;
         pixels_left--;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         x_pos = 0;
         y_pos = 0;
         x_inc = 0;
         y_inc = 0;
         pixels_left = 0;
         pixel_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pixel_queue.size() == 0) begin
               $error("pixel beat with nothing expected: x %0d y %0d last %0b",
                      rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.last_pixel);
               fail_count++;
            end else begin
               want = pixel_queue.pop_front();
               pixels_checked++;
               if (rsp_data.pixel_x !== want.pixel_x) begin
                  $error("pixel_x: expected %0d, got %0d", want.pixel_x, rsp_data.pixel_x);
                  fail_count++;
               end
               if (rsp_data.pixel_y !== want.pixel_y) begin
                  $error("pixel_y: expected %0d, got %0d", want.pixel_y, rsp_data.pixel_y);
                  fail_count++;
               end
               if (rsp_data.last_pixel !== want.last_pixel) begin
                  $error("last_pixel: expected %0b, got %0b",
                         want.last_pixel, rsp_data.last_pixel);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            trace_beat(req_data);
         end
      end
      pixels_pending = pixel_queue.size();
   end

endmodule

@@ tb/testbench.sv @@
module testbench;
   import dlr_pkg::*;

   localparam int ITEM_TARGET = 400;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int SETTLE_CYCLES = 2 * (FRAC_BITS_DEFAULT + 1) + 10;
   localparam int SILENCE_LIMIT = 4000;
   localparam int COORD_MAX = (1 << FIELD_BITS) - 1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pixels_pending;
   int lines_started;
   int empty_lines;
   int pixels_checked;
   int idle_steps;

   int items_sent = 0;
   int silent_cycles = 0;
   bit no_idle = 1'b0;
   bit hold_off_req = 1'b0;

   always #4 clock = ~clock;

   dda_line_rasterizer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   dlr_pixel_checker pixel_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .pixels_pending (pixels_pending),
      .lines_started  (lines_started),
      .empty_lines    (empty_lines),
      .pixels_checked (pixels_checked),
      .idle_steps     (idle_steps)
   );

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         silent_cycles <= 0;
      end else begin
         silent_cycles <= silent_cycles + 1;
      end
      if (silent_cycles >= SILENCE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_beat(input req_type beat);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic req_type step_beat();
      req_type     beat;
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      beat = noise[$bits(req_type)-1:0];
      beat.command = CMD_STEP;
      return beat;
   endfunction

   // start beat, then a number of step beats; only steps inside the line are counted
   task automatic draw(input int x0, input int y0, input int x1, input int y1,
                       input int n_steps);
      req_type beat;
      int      adx, ady, span;
      adx = (x1 > x0) ? x1 - x0 : x0 - x1;
      ady = (y1 > y0) ? y1 - y0 : y0 - y1;
      span = (adx >= ady) ? adx : ady;
      beat.command = CMD_START;
      beat.x_start = FIELD_BITS'(x0);
      beat.y_start = FIELD_BITS'(y0);
      beat.x_end = FIELD_BITS'(x1);
      beat.y_end = FIELD_BITS'(y1);
      send_beat(beat);
      repeat (n_steps) send_beat(step_beat());
      items_sent += 1 + ((n_steps < span) ? n_steps : span);
   endtask

   function automatic int near_coord(input int c);
      int v;
      v = c + int'($urandom_range(0, 30)) - 15;
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return v;
   endfunction

   // result side
   initial begin
      int stall_len;
      while (reset) @(posedge clock);
      forever begin
         stall_len = no_idle ? 0 : $urandom_range(0, 5);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_len += HOLD_OFF_CYCLES;
         end
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid || rsp_stall) @(posedge clock);
      end
   end

   initial begin
      int x0, y0, x1, y1, adx, ady, span, n, kind;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed lines
      send_beat(step_beat());
      draw(5, 5, 5, 5, 1);
      draw(0, 0, 3, 1, 5);
      draw(COORD_MAX, COORD_MAX, 0, 0, 3);
      draw(0, COORD_MAX, COORD_MAX, 0, 2);
      draw(COORD_MAX, 0, COORD_MAX - 3, COORD_MAX, 2);
      draw(10, 20, 12, 26, 6);

      // back up the result side while steps keep coming
      req_valid <= 1'b0;
      while (pixels_pending != 0) @(posedge clock);
      no_idle = 1'b1;
      hold_off_req = 1'b1;
      draw(100, 100, 160, 130, 60);
      no_idle = 1'b0;

      while (items_sent < ITEM_TARGET) begin
         no_idle = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            // noise: a stray step or a start that is dropped at once
            if ($urandom_range(0, 1) == 0) begin
               send_beat(step_beat());
            end else begin
               draw($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                    $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), 0);
            end
         end else if (kind == 1) begin
            // full range line, cut short
            draw($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                 $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                 $urandom_range(1, 10));
         end else begin
            x0 = $urandom_range(0, COORD_MAX);
            y0 = $urandom_range(0, COORD_MAX);
            x1 = near_coord(x0);
            y1 = near_coord(y0);
            adx = (x1 > x0) ? x1 - x0 : x0 - x1;
            ady = (y1 > y0) ? y1 - y0 : y0 - y1;
            span = (adx >= ady) ? adx : ady;
            case ($urandom_range(0, 5))
               0: n = (span > 0) ? $urandom_range(0, span - 1) : 0;
               1: n = span + $urandom_range(1, 2);
               default: n = span;
            endcase
            draw(x0, y0, x1, y1, n);
         end
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;

      while (pixels_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("lines started: %0d (%0d of zero length), pixels checked: %0d",
               lines_started, empty_lines, pixels_checked);
      $display("steps with no active line: %0d, one long result hold-off", idle_steps);
      if (fail_count == 0 && pixels_pending == 0) begin
         $display("== PASS ==");
      end else begin
         if (pixels_pending != 0) begin
            $error("%0d expected pixels never arrived", pixels_pending);
         end
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ dda_line_rasterizer_unit.f @@
rtl/core/dlr_pkg.sv
rtl/core/dda_line_rasterizer_unit.sv
tb/dlr_pixel_checker.sv
tb/testbench.sv
